@@ rtl/core/hwd_pkg.sv @@
// shared types and constants of the huffman tree walk decoder
// no dependencies; imported by the front, back and top level files
`timescale 1ns / 1ps

package hwd_pkg;

  localparam int MAX_NODES_DEF   = 511;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int SYM_W           = 8;
  localparam int COUNT_W         = 40;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_NODE  = 2'd1,
    REQ_COUNT = 2'd2,
    REQ_BIT   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_SYMBOL    = 2'd0,
    KIND_TREE_DONE = 2'd1,
    KIND_ERROR     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NOT_READY  = 2'd0,
    ERR_NO_CHILD   = 2'd1,
    ERR_OVERFLOW   = 2'd2,
    ERR_EXTRA_NODE = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    BK_EXEC = 2'd0,
    BK_NODE = 2'd1,
    BK_BIT  = 2'd2
  } bk_state_t;

  typedef struct packed {
    req_t               op;
    logic               is_leaf;
    logic [SYM_W-1:0]   sym;
    logic               code_bit;
    logic [COUNT_W-1:0] count;
  } hwd_item_t;

endpackage

@@ rtl/core/hwd_front.sv @@
// front end: accepts input words, classifies them and queues them for the back end
// depends on hwd_pkg
`timescale 1ns / 1ps

module hwd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic                         in_is_leaf,
  input  logic [hwd_pkg::SYM_W-1:0]    in_leaf_symbol,
  input  logic                         in_code_bit,
  input  logic [hwd_pkg::COUNT_W-1:0]  in_symbol_count,
  output logic                         q_valid,
  output hwd_pkg::hwd_item_t           q_item,
  input  logic                         q_take
);
  import hwd_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  hwd_item_t        slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  fill_r, fill_nxt;
  logic             push;
  logic             pop;
  hwd_item_t        new_item;

  assign in_stall = (fill_r == QC_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_take && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    new_item          = '0;
    new_item.op       = req_t'(in_req_type);
    new_item.is_leaf  = in_is_leaf;
    new_item.sym      = in_leaf_symbol;
    new_item.code_bit = in_code_bit;
    new_item.count    = in_symbol_count;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QP_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QP_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

@@ rtl/core/hwd_back.sv @@
// back end: tree loader and bit walker with node, link and slot memories, output register
// depends on hwd_pkg; fed from hwd_front
`timescale 1ns / 1ps

module hwd_back #(
  parameter int MAX_NODES   = hwd_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = hwd_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  hwd_pkg::hwd_item_t        q_item,
  output logic                      q_take,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_result_kind,
  output logic [hwd_pkg::SYM_W-1:0] out_decoded_symbol,
  output logic                      out_last_symbol,
  output logic [1:0]                out_error_code
);
  import hwd_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int STOP_W = $clog2(STACK_DEPTH + 1);

  // node info is leaf flag over byte; left child of an internal node is always the next node
  logic [SYM_W:0]      info_mem  [MAX_NODES];
  logic [NODE_W-1:0]   right_mem [MAX_NODES];
  // only right slots are kept, the left slot of the last internal node is implied
  logic [NODE_W-1:0]   stk_mem   [STACK_DEPTH];

  bk_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    nodes_used_r, nodes_used_nxt;
  logic [STOP_W-1:0]   stack_top_r, stack_top_nxt;
  logic                prev_internal_r, prev_internal_nxt;
  logic                ready_r, ready_nxt;
  logic [NODE_W-1:0]   pos_r, pos_nxt;
  logic [NODE_W-1:0]   cur_right_r, cur_right_nxt;
  logic [NODE_W-1:0]   root_right_r, root_right_nxt;
  logic                root_leaf_r, root_leaf_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [NODE_W-1:0]   child_r, child_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic                out_last_r, out_last_nxt;
  err_t                out_err_r, out_err_nxt;

  logic                go;
  logic                to_node;
  logic                to_bit;
  logic                overflow;
  logic [STOP_W-1:0]   after_pop;
  logic [STOP_W-1:0]   st_pop;
  logic [STOP_W-1:0]   st_new;
  logic [NODE_W-1:0]   n_idx;
  logic [NODE_W-1:0]   here_right;

  logic                info_we, right_we, stk_we, walk_re;
  logic [NODE_W-1:0]   info_wa, right_wa, right_wd, stk_wd;
  logic [SIDX_W-1:0]   stk_wa, stk_ra;
  logic [SYM_W:0]      info_wd;
  logic [SYM_W:0]      info_rd_r;
  logic [NODE_W-1:0]   right_rd_r;
  logic [NODE_W-1:0]   stk_rd_r;

  assign go         = !out_valid_r || !out_stall;
  assign n_idx      = nodes_used_r[NODE_W-1:0];
  assign here_right = (pos_r == '0) ? root_right_r : cur_right_r;
  assign stk_ra     = SIDX_W'(stack_top_r - STOP_W'(1));

  assign after_pop  = (nodes_used_r != '0 && stack_top_r != '0) ?
                      stack_top_r - STOP_W'(1) : stack_top_r;
  assign overflow   = (nodes_used_r >= CNT_W'(MAX_NODES)) ||
                      (!q_item.is_leaf && ((STOP_W+1)'(after_pop) + (STOP_W+1)'(2) >
                                           (STOP_W+1)'(STACK_DEPTH)));

  // which items need a second state (BK_NODE or BK_BIT) for a memory read
  assign to_node = (q_item.op == REQ_NODE) && !ready_r && !overflow;
  assign to_bit  = (q_item.op == REQ_BIT) && ready_r && (left_r != '0) &&
                   !(pos_r == '0 && root_leaf_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_EXEC: begin
        if (q_valid && go) begin
          if (to_node) begin
            state_nxt = BK_NODE;
          end else if (to_bit) begin
            state_nxt = BK_BIT;
          end
        end
      end
      BK_NODE: if (go) state_nxt = BK_EXEC;
      BK_BIT:  if (go) state_nxt = BK_EXEC;
      default: state_nxt = BK_EXEC;
    endcase
  end

  always_comb begin
    nodes_used_nxt    = nodes_used_r;
    stack_top_nxt     = stack_top_r;
    prev_internal_nxt = prev_internal_r;
    ready_nxt         = ready_r;
    pos_nxt           = pos_r;
    cur_right_nxt     = cur_right_r;
    root_right_nxt    = root_right_r;
    root_leaf_nxt     = root_leaf_r;
    left_nxt          = left_r;
    child_nxt         = child_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_kind_nxt      = out_kind_r;
    out_sym_nxt       = out_sym_r;
    out_last_nxt      = out_last_r;
    out_err_nxt       = out_err_r;
    q_take            = 1'b0;
    info_we           = 1'b0;
    info_wa           = n_idx;
    info_wd           = {q_item.is_leaf, q_item.sym};
    right_we          = 1'b0;
    right_wa          = stk_rd_r;
    right_wd          = n_idx;
    stk_we            = 1'b0;
    stk_wa            = '0;
    stk_wd            = n_idx;
    walk_re           = 1'b0;
    st_pop            = stack_top_r;
    st_new            = stack_top_r;

    case (state_r)
      BK_EXEC: begin
        if (q_valid && go) begin
          case (q_item.op)
            REQ_BEGIN: begin
              q_take            = 1'b1;
              nodes_used_nxt    = '0;
              stack_top_nxt     = '0;
              prev_internal_nxt = 1'b0;
              ready_nxt         = 1'b0;
              pos_nxt           = '0;
            end
            REQ_COUNT: begin
              q_take   = 1'b1;
              left_nxt = q_item.count;
              pos_nxt  = '0;
            end
            REQ_NODE: begin
              if (ready_r) begin
                q_take        = 1'b1;
                pos_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_ERROR;
                out_sym_nxt   = '0;
                out_last_nxt  = 1'b0;
                out_err_nxt   = ERR_EXTRA_NODE;
              end else if (overflow) begin
                q_take            = 1'b1;
                nodes_used_nxt    = '0;
                stack_top_nxt     = '0;
                prev_internal_nxt = 1'b0;
                pos_nxt           = '0;
                out_valid_nxt     = 1'b1;
                out_kind_nxt      = KIND_ERROR;
                out_sym_nxt       = '0;
                out_last_nxt      = 1'b0;
                out_err_nxt       = ERR_OVERFLOW;
              end
            end
            REQ_BIT: begin
              if (!ready_r) begin
                q_take        = 1'b1;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_ERROR;
                out_sym_nxt   = '0;
                out_last_nxt  = 1'b0;
                out_err_nxt   = ERR_NOT_READY;
              end else if (left_r == '0) begin
                q_take = 1'b1;
              end else if (pos_r == '0 && root_leaf_r) begin
                q_take        = 1'b1;
                pos_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_ERROR;
                out_sym_nxt   = '0;
                out_last_nxt  = 1'b0;
                out_err_nxt   = ERR_NO_CHILD;
              end else begin
                walk_re   = 1'b1;
                child_nxt = q_item.code_bit ? here_right : pos_r + NODE_W'(1);
              end
            end
            default: q_take = 1'b1;
          endcase
        end
      end
      BK_NODE: begin
        if (go) begin
          q_take  = 1'b1;
          info_we = 1'b1;
          if (nodes_used_r == '0) begin
            root_leaf_nxt = q_item.is_leaf;
          end else begin
            st_pop = stack_top_r - STOP_W'(1);
            if (!prev_internal_r) begin
              right_we = 1'b1;
              if (stk_rd_r == '0) root_right_nxt = n_idx;
            end
          end
          if (q_item.is_leaf) begin
            st_new            = st_pop;
            prev_internal_nxt = 1'b0;
          end else begin
            stk_we            = 1'b1;
            stk_wa            = st_pop[SIDX_W-1:0];
            st_new            = st_pop + STOP_W'(2);
            prev_internal_nxt = 1'b1;
          end
          stack_top_nxt  = st_new;
          nodes_used_nxt = nodes_used_r + CNT_W'(1);
          if (st_new == '0) begin
            ready_nxt     = 1'b1;
            pos_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_TREE_DONE;
            out_sym_nxt   = '0;
            out_last_nxt  = 1'b0;
            out_err_nxt   = ERR_NOT_READY;
          end
        end
      end
      BK_BIT: begin
        if (go) begin
          q_take = 1'b1;
          if (info_rd_r[SYM_W]) begin
            left_nxt      = left_r - COUNT_W'(1);
            pos_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_SYMBOL;
            out_sym_nxt   = info_rd_r[SYM_W-1:0];
            out_last_nxt  = (left_r == COUNT_W'(1));
            out_err_nxt   = ERR_NOT_READY;
          end else begin
            pos_nxt       = child_r;
            cur_right_nxt = right_rd_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= BK_EXEC;
      nodes_used_r    <= '0;
      stack_top_r     <= '0;
      prev_internal_r <= 1'b0;
      ready_r         <= 1'b0;
      pos_r           <= '0;
      left_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      nodes_used_r    <= nodes_used_nxt;
      stack_top_r     <= stack_top_nxt;
      prev_internal_r <= prev_internal_nxt;
      ready_r         <= ready_nxt;
      pos_r           <= pos_nxt;
      left_r          <= left_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_right_r  <= cur_right_nxt;
    root_right_r <= root_right_nxt;
    root_leaf_r  <= root_leaf_nxt;
    child_r      <= child_nxt;
    out_kind_r   <= out_kind_nxt;
    out_sym_r    <= out_sym_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (walk_re) info_rd_r <= info_mem[child_nxt];
  end

  always_ff @(posedge clk) begin
    if (right_we) right_mem[right_wa] <= right_wd;
    if (walk_re)  right_rd_r <= right_mem[child_nxt];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_last_symbol    = out_last_r;
  assign out_error_code     = out_err_r;

`ifndef NO_ASSERTIONS
  a_node_only_when_loading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_NODE) |-> !ready_r)
    else $error("node resolve while tree is ready");

  a_ready_has_no_open_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (stack_top_r == '0 && nodes_used_r != '0))
    else $error("ready tree with open slots");

  a_partial_tree_has_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (!ready_r && nodes_used_r != '0) |-> (stack_top_r != '0))
    else $error("partial tree without open slots");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stack_top_r <= STOP_W'(STACK_DEPTH)) && (nodes_used_r <= CNT_W'(MAX_NODES)))
    else $error("slot stack or node count out of range");

  a_second_cycle_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_EXEC && go) |=> (state_r == BK_EXEC))
    else $error("two cycle item did not finish");
`endif

endmodule

@@ rtl/core/huffman_tree_walk_decoder.sv @@
// top level of the huffman tree walk decoder
// depends on hwd_pkg, hwd_front and hwd_back
`timescale 1ns / 1ps

// Input words carry a request type: begin a new tree, a tree node in pre-order,
// a symbol count, or one code bit. Output words carry a decoded byte with a last
// flag, a tree load complete mark, or an error code.
// Both channels use valid/stall; a word moves on a clock edge with valid high and
// stall low. Input words enter a four word queue; the back end takes one from it.
// Output words come from a register: errors, a completed tree load and decoded
// bytes raise out_valid; begin, count and ignored bits give no output word.
// In the back end, begin, count and rejected items are done in BK_EXEC alone;
// an accepted tree node also passes BK_NODE (slot stack read, then node and link writes),
// and a walked code bit also passes BK_BIT (node memory read of the child, then resolve).
// Reset (synchronous, rst_n low) empties the queue and output register, leaves no
// tree loaded and the symbol count at zero; the node memories need no clearing.
// When the receiver stalls, the output word holds and the back end waits; the
// queue keeps accepting until full, then in_stall rises.
module huffman_tree_walk_decoder #(
  parameter int MAX_NODES   = hwd_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = hwd_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic                         in_is_leaf,
  input  logic [hwd_pkg::SYM_W-1:0]    in_leaf_symbol,
  input  logic                         in_code_bit,
  input  logic [hwd_pkg::COUNT_W-1:0]  in_symbol_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_result_kind,
  output logic [hwd_pkg::SYM_W-1:0]    out_decoded_symbol,
  output logic                         out_last_symbol,
  output logic [1:0]                   out_error_code
);
  import hwd_pkg::*;

  logic      q_valid;
  logic      q_take;
  hwd_item_t q_item;

  hwd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_is_leaf      (in_is_leaf),
    .in_leaf_symbol  (in_leaf_symbol),
    .in_code_bit     (in_code_bit),
    .in_symbol_count (in_symbol_count),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take)
  );

  hwd_back #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_take             (q_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_decoded_symbol (out_decoded_symbol),
    .out_last_symbol    (out_last_symbol),
    .out_error_code     (out_error_code)
  );

endmodule

@@ tb/sv/huffman_tree_walk_decoder_test.sv @@
// self-checking testbench of the huffman tree walk decoder: directed rows, then random scenarios
// words are scored against a local model of tree load and tree walk; depends on hwd_pkg
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_test;
  import hwd_pkg::*;

  localparam int NODE_LIMIT     = MAX_NODES_DEF;
  localparam int SLOT_LIMIT     = STACK_DEPTH_DEF;
  localparam int ORDINARY_ITEMS = 140;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRESSURE_AT    = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PLAN_LEN       = 26;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] sym;
    logic       last;
    err_t       err;
  } dec_word_t;

  typedef struct packed {
    req_t        op;
    logic        leaf;
    logic [7:0]  sym;
    logic        cbit;
    logic [39:0] cnt;
    logic        pinned;
    logic        pin_has;
    dec_word_t   pin_word;
  } stim_t;

  // pinned rows carry their own expectation, the others go through walk_step
  typedef struct packed {
    req_t        op;
    logic        leaf;
    logic [7:0]  sym;
    logic        cbit;
    logic [39:0] cnt;
    logic        pinned;
    logic        pin_has;
    kind_t       pin_kind;
    err_t        pin_err;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic        in_is_leaf = 1'b0;
  logic [7:0]  in_leaf_symbol = '0;
  logic        in_code_bit = 1'b0;
  logic [39:0] in_symbol_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_decoded_symbol;
  logic        out_last_symbol;
  logic [1:0]  out_error_code;

  huffman_tree_walk_decoder i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_is_leaf         (in_is_leaf),
    .in_leaf_symbol     (in_leaf_symbol),
    .in_code_bit        (in_code_bit),
    .in_symbol_count    (in_symbol_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_decoded_symbol (out_decoded_symbol),
    .out_last_symbol    (out_last_symbol),
    .out_error_code     (out_error_code)
  );

  plan_row_t plan_rows [PLAN_LEN] = '{
    '{REQ_BIT,   1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NOT_READY},
    '{REQ_NODE,  1'b1, 8'hff, 1'b0, 40'd0, 1'b1, 1'b1, KIND_TREE_DONE, ERR_NOT_READY},
    '{REQ_NODE,  1'b1, 8'h00, 1'b0, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_EXTRA_NODE},
    '{REQ_COUNT, 1'b0, 8'h00, 1'b0, 40'hff_ffff_ffff, 1'b1, 1'b0, KIND_SYMBOL, ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NO_CHILD},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NO_CHILD},
    '{REQ_BEGIN, 1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NOT_READY},
    '{REQ_NODE,  1'b0, 8'hff, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_NODE,  1'b1, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_NODE,  1'b0, 8'h3c, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_NODE,  1'b1, 8'ha5, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_NODE,  1'b1, 8'h5a, 1'b0, 40'd0, 1'b1, 1'b1, KIND_TREE_DONE, ERR_NOT_READY},
    '{REQ_COUNT, 1'b0, 8'h00, 1'b0, 40'd3, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b0, 40'd0, 1'b0, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b0, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b0, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b0, 40'd0, 1'b0, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_COUNT, 1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BEGIN, 1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_NODE,  1'b0, 8'h00, 1'b0, 40'd0, 1'b1, 1'b0, KIND_SYMBOL,    ERR_NOT_READY},
    '{REQ_BIT,   1'b0, 8'h00, 1'b1, 40'd0, 1'b1, 1'b1, KIND_ERROR,     ERR_NOT_READY}
  };

  stim_t     send_words[$];
  dec_word_t awaited_words[$];
  bit [15:0] leaf_path_q[$];
  int        leaf_len_q[$];

  // model state: node table, open slot stack and walk
  bit          tbl_leaf  [NODE_LIMIT];
  bit [7:0]    tbl_sym   [NODE_LIMIT];
  bit [9:0]    tbl_left  [NODE_LIMIT];
  bit [9:0]    tbl_right [NODE_LIMIT];
  bit [9:0]    slot_mem  [SLOT_LIMIT];
  int unsigned slot_top;
  int unsigned nodes_in;
  int unsigned walk_at;
  bit          tree_up;
  bit [39:0]   count_left;

  int send_idx = 0;
  int gap_left = 0;
  int burst_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic dec_word_t mk_word(kind_t k, bit [7:0] s, bit l, err_t e);
    dec_word_t r;
    r.kind = k;
    r.sym  = s;
    r.last = l;
    r.err  = e;
    return r;
  endfunction

  function automatic void tree_clear();
    nodes_in = 0;
    slot_top = 0;
    tree_up  = 1'b0;
    walk_at  = 0;
  endfunction

  function automatic void queue_stim(stim_t w);
    send_words.insert(send_words.size(), w);
  endfunction

  function automatic bit walk_step(input stim_t w, output dec_word_t r);
    int unsigned after_pop;
    int unsigned n;
    bit [9:0]    slot;
    bit [9:0]    link;
    bit [8:0]    child;
    r = '0;
    case (w.op)
      REQ_BEGIN: begin
        tree_clear();
        return 1'b0;
      end
      REQ_COUNT: begin
        count_left = w.cnt;
        walk_at = 0;
        return 1'b0;
      end
      REQ_NODE: begin
        if (tree_up) begin
          walk_at = 0;
          r = mk_word(KIND_ERROR, 8'h00, 1'b0, ERR_EXTRA_NODE);
          return 1'b1;
        end
        after_pop = (nodes_in > 0 && slot_top > 0) ? slot_top - 1 : slot_top;
        if (nodes_in >= NODE_LIMIT || (!w.leaf && after_pop + 2 > SLOT_LIMIT)) begin
          tree_clear();
          r = mk_word(KIND_ERROR, 8'h00, 1'b0, ERR_OVERFLOW);
          return 1'b1;
        end
        n = nodes_in;
        tbl_leaf[n]  = w.leaf;
        tbl_sym[n]   = w.sym;
        tbl_left[n]  = '0;
        tbl_right[n] = '0;
        if (n > 0 && slot_top > 0) begin
          slot = slot_mem[slot_top - 1];
          slot_top = slot_top - 1;
          link = {1'b1, n[8:0]};
          if (slot[0]) tbl_right[slot[9:1]] = link;
          else tbl_left[slot[9:1]] = link;
        end
        if (!w.leaf) begin
          // right slot below, left on top: left subtree comes first
          slot_mem[slot_top]     = {n[8:0], 1'b1};
          slot_mem[slot_top + 1] = {n[8:0], 1'b0};
          slot_top = slot_top + 2;
        end
        nodes_in = n + 1;
        if (slot_top == 0) begin
          tree_up = 1'b1;
          walk_at = 0;
          r = mk_word(KIND_TREE_DONE, 8'h00, 1'b0, ERR_NOT_READY);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (!tree_up) begin
          r = mk_word(KIND_ERROR, 8'h00, 1'b0, ERR_NOT_READY);
          return 1'b1;
        end
        if (count_left == 0) return 1'b0;
        link  = w.cbit ? tbl_right[walk_at] : tbl_left[walk_at];
        child = link[8:0];
        if (!link[9] || child >= NODE_LIMIT) begin
          walk_at = 0;
          r = mk_word(KIND_ERROR, 8'h00, 1'b0, ERR_NO_CHILD);
          return 1'b1;
        end
        if (tbl_leaf[child]) begin
          count_left = count_left - 40'd1;
          walk_at = 0;
          r = mk_word(KIND_SYMBOL, tbl_sym[child], count_left == 0, ERR_NOT_READY);
          return 1'b1;
        end
        walk_at = child;
        return 1'b0;
      end
    endcase
  endfunction

  // fields that the request type does not use are left random
  function automatic stim_t rand_word(req_t op);
    stim_t w;
    w.op       = op;
    w.leaf     = 1'($urandom_range(0, 1));
    w.sym      = 8'($urandom_range(0, 255));
    w.cbit     = 1'($urandom_range(0, 1));
    w.cnt      = {8'($urandom_range(0, 255)), 32'($urandom)};
    w.pinned   = 1'b0;
    w.pin_has  = 1'b0;
    w.pin_word = '0;
    return w;
  endfunction

  function automatic bit [39:0] pick_count(int n);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return {8'($urandom_range(0, 255)), 32'($urandom)};
      default: return 40'($urandom_range(1, n));
    endcase
  endfunction

  task automatic add_node(bit leaf);
    stim_t w;
    w = rand_word(REQ_NODE);
    w.leaf = leaf;
    queue_stim(w);
  endtask

  task automatic add_bit(bit b);
    stim_t w;
    w = rand_word(REQ_BIT);
    w.cbit = b;
    queue_stim(w);
  endtask

  task automatic add_count(bit [39:0] c);
    stim_t w;
    w = rand_word(REQ_COUNT);
    w.cnt = c;
    queue_stim(w);
  endtask

  // pre-order tree of at most budget nodes, stopped after cut nodes when cut >= 0
  task automatic gen_tree(int budget, int cut);
    bit [15:0] open_path[$];
    int        open_len[$];
    bit [15:0] p;
    int        l;
    int        made;
    bit        as_leaf;
    leaf_path_q.delete();
    leaf_len_q.delete();
    made = 0;
    open_path.insert(open_path.size(), 16'd0);
    open_len.insert(open_len.size(), 0);
    while (open_path.size() != 0 && made != cut) begin
      p = open_path.pop_back();
      l = open_len.pop_back();
      as_leaf = (l >= 12) || (made + open_path.size() + 3 > budget) ||
                ($urandom_range(0, 99) < ((l == 0) ? 5 : 35));
      add_node(as_leaf);
      made++;
      if (as_leaf) begin
        leaf_path_q.insert(leaf_path_q.size(), p);
        leaf_len_q.insert(leaf_len_q.size(), l);
      end else begin
        open_path.insert(open_path.size(), p | (16'd1 << l));
        open_len.insert(open_len.size(), l + 1);
        open_path.insert(open_path.size(), p);
        open_len.insert(open_len.size(), l + 1);
      end
    end
  endtask

  task automatic gen_walk(int nsym);
    int idx;
    for (int i = 0; i < nsym; i++) begin
      if (leaf_len_q.size() == 0) return;
      idx = $urandom_range(0, leaf_len_q.size() - 1);
      if (leaf_len_q[idx] == 0) add_bit(1'($urandom_range(0, 1)));
      for (int d = 0; d < leaf_len_q[idx]; d++) begin
        // now and then a stray bit knocks the walk off its path
        if ($urandom_range(0, 39) == 0) add_bit(1'($urandom_range(0, 1)));
        add_bit(leaf_path_q[idx][d]);
      end
    end
  endtask

  // spine of internal nodes with a leaf on each left side, filling the whole node table
  task automatic add_spine(bit complete);
    int pick;
    queue_stim(rand_word(REQ_BEGIN));
    for (int k = 0; k < 255; k++) begin
      add_node(1'b0);
      add_node(1'b1);
    end
    add_node(complete);
    if (complete) begin
      add_count(40'd3);
      repeat (255) add_bit(1'b1);
      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(0, 40);
        repeat (pick) add_bit(1'b1);
        add_bit(1'b0);
      end
      add_node(1'($urandom_range(0, 1)));
    end else begin
      add_node(1'($urandom_range(0, 1)));
      add_node(1'b1);
    end
  endtask

  always @(posedge clk) begin : drive_words
    dec_word_t w;
    bit        has;
    bit        took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        has = walk_step(send_words[send_idx], w);
        if (send_words[send_idx].pinned) begin
          has = send_words[send_idx].pin_has;
          w   = send_words[send_idx].pin_word;
        end
        if (has) awaited_words.insert(awaited_words.size(), w);
        send_idx++;
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_idx < send_words.size()) begin
          in_valid        <= 1'b1;
          in_req_type     <= send_words[send_idx].op;
          in_is_leaf      <= send_words[send_idx].leaf;
          in_leaf_symbol  <= send_words[send_idx].sym;
          in_code_bit     <= send_words[send_idx].cbit;
          in_symbol_count <= send_words[send_idx].cnt;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall modes, plus one long hold-off so the input queue fills
  always @(posedge clk) begin : stall_words
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && send_idx >= PRESSURE_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_words
    dec_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: kind %0d sym %0h last %0d err %0d",
                   out_result_kind, out_decoded_symbol, out_last_symbol, out_error_code);
      end else begin
        w = awaited_words.pop_front();
        if (w.kind !== out_result_kind || w.sym !== out_decoded_symbol ||
            w.last !== out_last_symbol || w.err !== out_error_code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("word mismatch: expected kind %0d sym %0h last %0d err %0d, %s %0d %0h %0d %0d",
                     w.kind, w.sym, w.last, w.err, "got",
                     out_result_kind, out_decoded_symbol, out_last_symbol, out_error_code);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main_seq
    stim_t w;
    int    scen;
    int    big;
    int    mark;
    int    n;
    foreach (plan_rows[r]) begin
      w = rand_word(plan_rows[r].op);
      w.leaf     = plan_rows[r].leaf;
      w.sym      = plan_rows[r].sym;
      w.cbit     = plan_rows[r].cbit;
      w.cnt      = plan_rows[r].cnt;
      w.pinned   = plan_rows[r].pinned;
      w.pin_has  = plan_rows[r].pin_has;
      w.pin_word = mk_word(plan_rows[r].pin_kind, 8'h00, 1'b0, plan_rows[r].pin_err);
      queue_stim(w);
    end

    scen = 0;
    big  = 0;
    while (send_words.size() < PLAN_LEN + ORDINARY_ITEMS + big || scen < 8) begin
      mark = send_words.size();
      if (scen == 5) begin
        // stack runs out on the 256th internal node in a row
        queue_stim(rand_word(REQ_BEGIN));
        repeat (256) add_node(1'b0);
        add_node(1'b1);
        big += send_words.size() - mark;
      end else if (scen == 6 || scen == 7) begin
        add_spine(scen == 7);
        big += send_words.size() - mark;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(3, 12))
              queue_stim(rand_word(req_t'(2'($urandom_range(0, 3)))));
          end
          1: begin
            queue_stim(rand_word(REQ_BEGIN));
            gen_tree($urandom_range(3, 15), $urandom_range(1, 4));
            repeat ($urandom_range(1, 4)) add_bit(1'($urandom_range(0, 1)));
            add_count(pick_count(4));
            gen_walk($urandom_range(0, 2));
          end
          default: begin
            if ($urandom_range(0, 9) != 0) queue_stim(rand_word(REQ_BEGIN));
            gen_tree(($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 15), -1);
            if ($urandom_range(0, 7) == 0) add_node(1'($urandom_range(0, 1)));
            n = $urandom_range(1, 12);
            add_count(pick_count(n));
            gen_walk(n + $urandom_range(0, 2));
          end
        endcase
      end
      scen++;
    end

    tree_clear();
    count_left = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (send_idx < send_words.size() || awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hwd_pkg.sv
rtl/core/hwd_front.sv
rtl/core/hwd_back.sv
rtl/core/huffman_tree_walk_decoder.sv
tb/sv/huffman_tree_walk_decoder_test.sv
